### rtl/fat12_cluster_chain_walker_core_defines.svh
// Assertion macros for the checker of the cluster chain walker.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw checker: same-cycle rule violated");

// The consequent must hold in the cycle after the antecedent.
`define FCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw checker: next-cycle rule violated");

`endif

### rtl/fcw_pkg.sv
package fcw_pkg;

    localparam int TABLE_BYTES = 8192;
    localparam int MAX_RUN     = 64;
    localparam int TBL_AW      = $clog2(TABLE_BYTES);
    localparam int RUN_W       = $clog2(MAX_RUN + 1);

    localparam logic [11:0] END_MARK = 12'hFF8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_WALK = 1'b1;

    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SPC        = 1'b1;

    localparam logic [1:0] ST_CONTINUE = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_LIMIT    = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [12:0] byte_address;
        logic [7:0]  byte_value;
        logic [11:0] first_cluster;
    } item_t;

    typedef struct packed {
        logic [19:0] lba;
        logic [11:0] cluster;
        logic [11:0] next_cluster;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD_LO,
        S_RD_HI,
        S_OUT
    } state_t;

endpackage

### rtl/fat12_cluster_chain_walker_core.sv
// FAT12 cluster chain walker. A load beat (kind 0) writes one byte of the
// allocation table and gives no result. A walk beat (kind 1) follows the
// chain from first_cluster and gives one result beat per cluster, the last
// one flagged; item_ready stays low until the final result has been taken.
// For each cluster the two bytes of its 12-bit entry come one after the
// other through the single registered read port of the table memory, and
// the sector address is formed by one 12x8 multiplier and one adder in
// between. A cluster below 2 gives a bad-cluster result without reading
// the table. The table comes up undefined; walks must only touch bytes
// that were loaded.
module fat12_cluster_chain_walker_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  fcw_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output fcw_pkg::result_t result,
    input  logic            cfg_write,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data
);
    import fcw_pkg::*;

    logic [7:0] mem [TABLE_BYTES];

    state_t          state_reg, state_next;
    logic [15:0]     data_start_reg;
    logic [7:0]      spc_reg;
    logic [11:0]     cluster_reg, cluster_next;
    logic [RUN_W-1:0] run_count_reg, run_count_next;
    logic [7:0]      lo_reg, lo_next;
    logic [19:0]     prod_reg, prod_next;
    result_t         out_reg, out_next;
    logic [7:0]      rd_data_reg;
    logic            rd_oob_reg;

    logic [13:0] triple;
    logic [13:0] off_lo;
    logic [13:0] off_hi;
    logic [13:0] rd_addr;
    logic [7:0]  rd_byte;
    logic [15:0] pair;
    logic [11:0] entry;
    logic [11:0] clu_m2;
    logic [19:0] lba;
    logic        load_fire;

    // Byte offset of the entry is cluster * 3 / 2.
    assign triple  = {2'b00, cluster_reg} + {1'b0, cluster_reg, 1'b0};
    assign off_lo  = {1'b0, triple[13:1]};
    assign off_hi  = off_lo + 14'd1;
    assign rd_addr = (state_reg == S_RD_LO) ? off_hi : off_lo;

    // Bytes past the end of the table read as 0xFF.
    assign rd_byte = rd_oob_reg ? 8'hFF : rd_data_reg;
    assign pair    = {rd_byte, lo_reg};
    assign entry   = cluster_reg[0] ? pair[15:4] : pair[11:0];
    assign clu_m2  = cluster_reg - 12'd2;
    assign lba     = 20'(data_start_reg) + prod_reg;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign result       = out_reg;
    assign load_fire    = item_valid && item_ready && (item.kind == KIND_LOAD)
                          && ({1'b0, item.byte_address} < 14'(TABLE_BYTES));

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            mem[item.byte_address[TBL_AW-1:0]] <= item.byte_value;
        end
        rd_data_reg <= mem[rd_addr[TBL_AW-1:0]];
        rd_oob_reg  <= (rd_addr >= 14'(TABLE_BYTES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            data_start_reg <= 16'd33;
            spc_reg        <= 8'd1;
            cluster_reg    <= '0;
            run_count_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cluster_reg   <= cluster_next;
            run_count_reg <= run_count_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DATA_START: data_start_reg <= cfg_data;
                    CFG_SPC:        spc_reg        <= cfg_data[7:0];
                    default:        data_start_reg <= data_start_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cluster_next   = cluster_reg;
        run_count_next = run_count_reg;
        lo_next        = lo_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (item.kind == KIND_WALK))
                begin
                    cluster_next   = item.first_cluster;
                    run_count_next = '0;
                    state_next     = S_START;
                end
            end
            S_START:
            begin
                run_count_next = run_count_reg + RUN_W'(1);
                if (cluster_reg < 12'd2)
                begin
                    out_next.lba          = '0;
                    out_next.cluster      = cluster_reg;
                    out_next.next_cluster = '0;
                    out_next.status       = ST_BAD;
                    out_next.last         = 1'b1;
                    state_next            = S_OUT;
                end
                else
                begin
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                lo_next    = rd_byte;
                prod_next  = 20'(clu_m2) * 20'(spc_reg);
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                out_next.lba          = lba;
                out_next.cluster      = cluster_reg;
                out_next.next_cluster = entry;
                if (entry >= END_MARK)
                begin
                    out_next.status = ST_END;
                    out_next.last   = 1'b1;
                end
                else if (run_count_reg >= RUN_W'(MAX_RUN))
                begin
                    out_next.status = ST_LIMIT;
                    out_next.last   = 1'b1;
                end
                else
                begin
                    out_next.status = ST_CONTINUE;
                    out_next.last   = 1'b0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    if (out_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cluster_next = out_reg.next_cluster;
                        state_next   = S_START;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/fcw_checker.sv
`include "fat12_cluster_chain_walker_core_defines.svh"

module fcw_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input fcw_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input fcw_pkg::result_t result
);
    import fcw_pkg::*;

    // A walk is in progress while a result is shown, so no new beat is taken.
    `FCW_ASSERT_NOW(a_no_overlap, result_valid, !item_ready)

    // Only a terminating status closes a walk.
    `FCW_ASSERT_NOW(a_last_status, result_valid,
        result.last == (result.status != ST_CONTINUE))

    // A bad cluster result carries a cluster below 2 and zero fields.
    `FCW_ASSERT_NOW(a_bad_fields, result_valid && (result.status == ST_BAD),
        (result.cluster < 12'd2) && (result.lba == 20'd0) && (result.next_cluster == 12'd0))

    // Once a walk beat is taken, input stays closed until its results finish.
    `FCW_ASSERT_NEXT(a_walk_busy, item_valid && item_ready && (item.kind == KIND_WALK),
        !item_ready)

    // A result that is not the last keeps the walk going.
    `FCW_ASSERT_NEXT(a_walk_continues, result_valid && result_ready && !result.last,
        !item_ready)

endmodule

bind fat12_cluster_chain_walker_core fcw_checker u_fcw_checker (.*);

### bench/fat12_cluster_chain_walker_core_tb.sv
module fat12_cluster_chain_walker_core_tb;
    import fcw_pkg::*;

    localparam int TAIL_EOC  = 0;
    localparam int TAIL_BAD  = 1;
    localparam int TAIL_LOOP = 2;

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_COMB   = 2;
    localparam int RX_SPARSE = 3;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    // Keeps a copy of the allocation table and the two registers, and turns
    // every accepted walk beat into the list of hops the block must report.
    class chain_scoreboard;
        bit [7:0]  fat [TABLE_BYTES];
        bit        loaded [TABLE_BYTES];
        bit [15:0] data_start;
        bit [7:0]  spc;
        result_t   pending_hops [$];
        int        mismatches;

        function new();
            data_start = 16'd33;
            spc = 8'd1;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, bit [15:0] value);
            if (idx == CFG_DATA_START)
                data_start = value;
            else
                spc = value[7:0];
        endfunction

        function bit readable(int addr);
            return addr >= TABLE_BYTES || loaded[addr];
        endfunction

        function bit [7:0] byte_at(int addr);
            return addr >= TABLE_BYTES ? 8'hFF : fat[addr];
        endfunction

        // Follows the chain from head. With record set, each hop is queued
        // as an expected result. Returns 0 when the walk would touch a table
        // byte that was never loaded.
        function bit trace_walk(bit [11:0] head, bit record);
            bit [11:0]   cur;
            bit [15:0]   pair;
            int          off;
            int unsigned lba32;
            result_t     r;
            cur = head;
            for (int n = 1; n <= MAX_RUN; n++)
            begin
                r.cluster = cur;
                if (cur < 2)
                begin
                    r.lba = '0;
                    r.next_cluster = '0;
                    r.status = ST_BAD;
                end
                else
                begin
                    off = int'(cur) * 3 / 2;
                    if (!readable(off) || !readable(off + 1))
                        return 1'b0;
                    pair = {byte_at(off + 1), byte_at(off)};
                    r.next_cluster = cur[0] ? pair[15:4] : pair[11:0];
                    lba32 = data_start + (int'(cur) - 2) * spc;
                    r.lba = lba32[19:0];
                    if (r.next_cluster >= END_MARK)
                        r.status = ST_END;
                    else if (n == MAX_RUN)
                        r.status = ST_LIMIT;
                    else
                        r.status = ST_CONTINUE;
                end
                r.last = (r.status != ST_CONTINUE);
                if (record)
                    pending_hops.push_back(r);
                if (r.last)
                    return 1'b1;
                cur = r.next_cluster;
            end
            return 1'b1;
        endfunction

        function void note_item(item_t it);
            if (it.kind == KIND_LOAD)
            begin
                if (int'(it.byte_address) < TABLE_BYTES)
                begin
                    fat[it.byte_address] = it.byte_value;
                    loaded[it.byte_address] = 1'b1;
                end
            end
            else
                void'(trace_walk(it.first_cluster, 1'b1));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_hops.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat for cluster %0d", got.cluster));
                return;
            end
            want = pending_hops.pop_front();
            if (got.lba !== want.lba)
                report_mismatch($sformatf("cluster %0d lba %0d, want %0d",
                                          want.cluster, got.lba, want.lba));
            if (got.cluster !== want.cluster)
                report_mismatch($sformatf("cluster %0d, want %0d", got.cluster, want.cluster));
            if (got.next_cluster !== want.next_cluster)
                report_mismatch($sformatf("cluster %0d next %0h, want %0h",
                                          want.cluster, got.next_cluster, want.next_cluster));
            if (got.status !== want.status)
                report_mismatch($sformatf("cluster %0d status %0d, want %0d",
                                          want.cluster, got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("cluster %0d last %0b, want %0b",
                                          want.cluster, got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    chain_scoreboard sb = new();
    int        items_sent = 0;
    int        burst_left = 0;
    bit        hold_req = 1'b0;
    bit [11:0] known_clusters [$];

    fat12_cluster_chain_walker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Entered and left at a falling edge. The sender runs in bursts with
    // idle gaps between them.
    task automatic send_item(item_t it);
        if (burst_left == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_load(bit [12:0] addr, bit [7:0] value);
        item_t it;
        it.kind = KIND_LOAD;
        it.byte_address = addr;
        it.byte_value = value;
        it.first_cluster = 12'($urandom);
        send_item(it);
    endtask

    task automatic send_walk(bit [11:0] head);
        item_t it;
        it.kind = KIND_WALK;
        it.byte_address = 13'($urandom);
        it.byte_value = 8'($urandom);
        it.first_cluster = head;
        send_item(it);
    endtask

    // Writes a 12-bit entry with two byte loads, keeping the neighbor's
    // nibble in the shared byte.
    task automatic set_entry(bit [11:0] clu, bit [11:0] value);
        int       off;
        bit [7:0] lo, hi;
        off = int'(clu) * 3 / 2;
        lo = sb.fat[off];
        hi = sb.fat[off + 1];
        if (clu[0])
        begin
            lo[7:4] = value[3:0];
            hi = value[11:4];
        end
        else
        begin
            lo = value[7:0];
            hi[3:0] = value[11:8];
        end
        if ($urandom_range(0, 1))
        begin
            send_load(13'(off), lo);
            send_load(13'(off + 1), hi);
        end
        else
        begin
            send_load(13'(off + 1), hi);
            send_load(13'(off), lo);
        end
    endtask

    task automatic run_chain(bit [11:0] path [$], bit [11:0] tail);
        foreach (path[i])
        begin
            set_entry(path[i], (i + 1 < path.size()) ? path[i + 1] : tail);
            known_clusters.push_back(path[i]);
        end
        send_walk(path[0]);
    endtask

    task automatic random_chain(int len, int ending);
        bit        used [4096];
        bit [11:0] path [$];
        bit [11:0] c, tail;
        while (path.size() < len)
        begin
            c = 12'($urandom_range(2, 4095));
            if (!used[c])
            begin
                used[c] = 1'b1;
                path.push_back(c);
            end
        end
        case (ending)
            TAIL_EOC: tail = 12'($urandom_range(int'(END_MARK), 12'hFFF));
            TAIL_BAD: tail = 12'($urandom_range(0, 1));
            default:  tail = path[$urandom_range(0, len - 1)];
        endcase
        run_chain(path, tail);
    endtask

    task automatic random_traffic(int budget, bit full_chain);
        int        stop_at, pick, len, ending;
        bit [11:0] c;
        stop_at = items_sent + budget;
        // A chain of exactly the run limit that ends on its last hop.
        if (full_chain)
            random_chain(MAX_RUN, TAIL_EOC);
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = ($urandom_range(0, 99) < 5) ? $urandom_range(MAX_RUN - 1, MAX_RUN + 1)
                                                   : $urandom_range(1, 6);
                pick = $urandom_range(0, 9);
                ending = pick < 6 ? TAIL_EOC : (pick < 8 ? TAIL_BAD : TAIL_LOOP);
                random_chain(len, ending);
            end
            else if (pick < 82)
                send_load(13'($urandom_range(0, TABLE_BYTES - 1)), 8'($urandom));
            else if (pick < 95)
            begin
                // Walk from a random cluster or else from somewhere inside an older
                // chain, if the walk stays on loaded bytes; else from cluster 0 or 1.
                c = 12'($urandom);
                if (!sb.trace_walk(c, 1'b0))
                    c = known_clusters[$urandom_range(0, known_clusters.size() - 1)];
                if (!sb.trace_walk(c, 1'b0))
                    c = 12'($urandom_range(0, 1));
                send_walk(c);
            end
            else
                send_walk(12'($urandom_range(0, 1)));
        end
    endtask

    task automatic settle();
        item_valid = 1'b0;
        burst_left = 0;
        while (sb.pending_hops.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Receiver: picks a new stall pattern whenever its random span runs out, and
    // on request holds off long enough for the walker to back up its input.
    initial
    begin
        int mode, span, tick;
        result_ready = 1'b0;
        mode = RX_OPEN;
        span = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(RX_OPEN, RX_SPARSE);
                span = $urandom_range(4, 60);
            end
            span--;
            tick++;
            case (mode)
                RX_OPEN: result_ready = 1'b1;
                RX_COIN: result_ready = 1'($urandom_range(0, 1));
                RX_COMB: result_ready = (tick % 3 != 0);
                default: result_ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial
    begin
        #4000000;
        $display("fat12_cluster_chain_walker_core test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_DATA_START;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset register values.
        send_walk(12'd0);
        send_walk(12'd1);
        run_chain('{12'd4095}, 12'hFFF);
        run_chain('{12'd2}, END_MARK);
        run_chain('{12'd3, 12'hFF7}, END_MARK);
        run_chain('{12'd5}, 12'd1);
        run_chain('{12'd7, 12'd6}, 12'd7);
        run_chain('{12'd9}, 12'd9);
        send_load(13'(TABLE_BYTES - 1), 8'hFF);
        send_load(13'd0, 8'h00);
        random_traffic(90, 1'b0);

        settle();
        write_reg(CFG_DATA_START, 16'd0);
        write_reg(CFG_SPC, 16'd1);
        hold_req = 1'b1;
        random_traffic(90, 1'b0);

        settle();
        write_reg(CFG_DATA_START, 16'hFFFF);
        write_reg(CFG_SPC, 16'd128);
        random_traffic(150, 1'b1);

        settle();
        write_reg(CFG_DATA_START, 16'($urandom));
        write_reg(CFG_SPC, 16'($urandom_range(1, 128)));
        random_traffic(90, 1'b0);

        settle();
        if (sb.mismatches == 0)
            $display("fat12_cluster_chain_walker_core test passed");
        else
            $display("fat12_cluster_chain_walker_core test failed");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/fcw_pkg.sv
rtl/fat12_cluster_chain_walker_core.sv
rtl/fcw_checker.sv
bench/fat12_cluster_chain_walker_core_tb.sv
